// File: rtl/matp_pkg.sv
// Shared types and constants for the multi-axis trapezoid profile generator.
package matp_pkg;

   localparam int POS_W   = 48;
   localparam int SPD_W   = 32;
   localparam int MS_W    = 16;
   localparam int TICK_W  = 16;
   localparam int LEFT_W  = 49;
   localparam int DLT_W   = 41;
   localparam int PITCH_W = 40;
   localparam int DVD_W   = 64;
   localparam int DSR_W   = 32;
   localparam int CNT_W   = 7;
   localparam int REQ_DW  = 168;
   localparam int RSP_DW  = 88;

   localparam logic [SPD_W-1:0] SPEED_FLOOR = 32'd7;

   typedef enum logic [1:0] {
      PH_DONE   = 2'd0,
      PH_ACC    = 2'd1,
      PH_CRUISE = 2'd2,
      PH_DEC    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_ABS  = 2'd1,
      REQ_REL  = 2'd2,
      REQ_STOP = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/matp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module matp_div
   import matp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DSR_W:0]   shifted;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      if (div_req.start) begin
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = DSR_W'(shifted - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DSR_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

// File: rtl/multi_axis_trapezoid_profile.sv
// Multi-axis trapezoid profile generator: sequencer, shared multiplier, axis state.
// Command word: accepted in IDLE, applied in CMD, result valid in EMIT; ready again once taken.
// Tick word: a moving axis runs LOAD, up to two waits on the shared divider (braking
// time, ramp delta), then the multiply and update steps; a done axis goes from LOAD to
// EMIT. Each result may be held by rsp_tready. One word is worked on at a time.
// Synchronous reset: all axes done at position 0, speeds 0, ramp times 1 ms.
module multi_axis_trapezoid_profile
   import matp_pkg::*;
#(
   parameter int NUM_AXES = 8
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // home_flag, axis, start_speed, max_speed, acc_time, dec_time, move_amount,
   // tick_time, zero pad
   input  logic [REQ_DW-1:0] req_tdata,
   // req_type
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // axis_out, position, speed, moving, accepted, zero pad
   output logic [RSP_DW-1:0] rsp_tdata,
   output logic              rsp_tlast
);

   localparam int NSTORE = (NUM_AXES < 8) ? NUM_AXES : 8;
   localparam int IW     = (NSTORE > 1) ? $clog2(NSTORE) : 1;

   typedef enum logic [15:0] {
      S_IDLE    = 16'h0001,
      S_CMD     = 16'h0002,
      S_LOAD    = 16'h0004,
      S_BMUL    = 16'h0008,
      S_BDIV_GO = 16'h0010,
      S_BDIV    = 16'h0020,
      S_BMUL2   = 16'h0040,
      S_BRK     = 16'h0080,
      S_DECIDE  = 16'h0100,
      S_RMUL    = 16'h0200,
      S_RDIV_GO = 16'h0400,
      S_RDIV    = 16'h0800,
      S_RAPPLY  = 16'h1000,
      S_PMUL    = 16'h2000,
      S_STEP    = 16'h4000,
      S_EMIT    = 16'h8000
   } state_type;

   // per-axis state
   phase_type               ph_ff  [NSTORE];
   logic signed [POS_W-1:0] pos_ff [NSTORE];
   logic signed [POS_W-1:0] tgt_ff [NSTORE];
   logic [SPD_W-1:0]        spd_ff [NSTORE];
   logic [SPD_W-1:0]        vs_ff  [NSTORE];
   logic [SPD_W-1:0]        vm_ff  [NSTORE];
   logic [MS_W-1:0]         acc_ff [NSTORE];
   logic [MS_W-1:0]         dec_ff [NSTORE];

   state_type               state_ff;
   logic [2:0]              cur_ff;
   logic                    tickm_ff;
   logic [TICK_W-1:0]       tick_ff;
   req_kind_type            kind_ff;
   logic                    home_ff;
   logic [SPD_W-1:0]        cvs_ff, cvm_ff;
   logic [MS_W-1:0]         cacc_ff, cdec_ff;
   logic signed [POS_W-1:0] amt_ff;

   // working copy of the axis under work
   phase_type               wph_ff;
   logic signed [POS_W-1:0] wpos_ff, wtgt_ff;
   logic [SPD_W-1:0]        wsp_ff, wvs_ff, wvm_ff;
   logic [MS_W-1:0]         wacc_ff, wdec_ff;
   logic [LEFT_W-1:0]       left_ff;
   logic [SPD_W-1:0]        rng_ff, dv_ff;
   logic [POS_W-1:0]        brake_ff;
   logic                    wacpt_ff, winv_ff;
   logic [2*SPD_W-1:0]      prod_ff;

   logic [SPD_W-1:0]        mul_a, mul_b;
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic [IW-1:0]           idx;
   logic                    in_range;
   logic                    last_axis;

   assign idx       = cur_ff[IW-1:0];
   assign in_range  = 32'(cur_ff) < NUM_AXES;
   assign last_axis = cur_ff == 3'(NSTORE - 1);

   matp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // divider requests: braking time, then ramp delta
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      if (state_ff == S_BDIV_GO) begin
         div_req.start    = 1'b1;
         div_req.dividend = {prod_ff[DVD_W-17:0], 16'd0};
         div_req.divisor  = rng_ff;
      end else if (state_ff == S_RDIV_GO) begin
         div_req.start    = 1'b1;
         div_req.dividend = prod_ff;
         div_req.divisor  = (wph_ff == PH_ACC) ? {8'd0, wacc_ff, 8'd0}
                                               : {8'd0, wdec_ff, 8'd0};
      end
   end

   // shared multiplier operand select
   logic [SPD_W:0]   vsum;
   logic [SPD_W-1:0] spf;
   always_comb begin
      vsum  = {1'b0, wsp_ff} + {1'b0, wvs_ff};
      spf   = (wsp_ff < SPEED_FLOOR) ? SPEED_FLOOR : wsp_ff;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_BMUL: begin
            mul_a = dv_ff;
            mul_b = {16'd0, wdec_ff};
         end
         S_BMUL2: begin
            mul_a = vsum[SPD_W:1];
            mul_b = div_rsp.quotient[SPD_W-1:0];
         end
         S_RMUL: begin
            mul_a = rng_ff;
            mul_b = {16'd0, tick_ff};
         end
         S_PMUL: begin
            mul_a = spf;
            mul_b = {16'd0, tick_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // combinational helpers for LOAD, CMD, RAPPLY and STEP
   logic signed [POS_W:0]   diff;
   logic signed [POS_W:0]   rel_sum;
   logic signed [POS_W-1:0] rel_tgt;
   logic [DLT_W-1:0]        dlt, acc_sum, dec_lim;
   logic [PITCH_W-1:0]      pitch;
   logic                    bval;
   logic [SPD_W-1:0]        ld_rng, ld_dv;
   always_comb begin
      diff    = {tgt_ff[idx][POS_W-1], tgt_ff[idx]} - {pos_ff[idx][POS_W-1], pos_ff[idx]};
      bval    = (vm_ff[idx] > vs_ff[idx]) && (spd_ff[idx] > vs_ff[idx]);
      ld_rng  = (vm_ff[idx] > vs_ff[idx]) ? vm_ff[idx] - vs_ff[idx]
                                          : vs_ff[idx] - vm_ff[idx];
      ld_dv   = spd_ff[idx] - vs_ff[idx];
      if (ld_dv > ld_rng) ld_dv = ld_rng;
      rel_sum = {tgt_ff[idx][POS_W-1], tgt_ff[idx]} + {amt_ff[POS_W-1], amt_ff};
      if (rel_sum[POS_W] != rel_sum[POS_W-1])
         rel_tgt = rel_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      else
         rel_tgt = rel_sum[POS_W-1:0];
      dlt     = div_rsp.quotient[DLT_W-1:0];
      acc_sum = {9'd0, wsp_ff} + dlt;
      dec_lim = {9'd0, wvs_ff} + dlt;
      pitch   = prod_ff[PITCH_W+7:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_ff   <= '0;
         tickm_ff <= 1'b0;
         for (int i = 0; i < NSTORE; i++) begin
            ph_ff[i]  <= PH_DONE;
            pos_ff[i] <= '0;
            tgt_ff[i] <= '0;
            spd_ff[i] <= '0;
            vs_ff[i]  <= '0;
            vm_ff[i]  <= '0;
            acc_ff[i] <= MS_W'(1);
            dec_ff[i] <= MS_W'(1);
         end
      end else begin
         prod_ff <= mul_a * mul_b;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff  <= req_kind_type'(req_tuser);
                  home_ff  <= req_tdata[0];
                  cvs_ff   <= req_tdata[35:4];
                  cvm_ff   <= req_tdata[67:36];
                  cacc_ff  <= (req_tdata[83:68] == '0) ? MS_W'(1) : req_tdata[83:68];
                  cdec_ff  <= (req_tdata[99:84] == '0) ? MS_W'(1) : req_tdata[99:84];
                  amt_ff   <= req_tdata[147:100];
                  tick_ff  <= req_tdata[163:148];
                  if (req_kind_type'(req_tuser) == REQ_TICK) begin
                     tickm_ff <= 1'b1;
                     cur_ff   <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     tickm_ff <= 1'b0;
                     cur_ff   <= req_tdata[3:1];
                     state_ff <= S_CMD;
                  end
               end
            end
            S_CMD: begin
               state_ff <= S_EMIT;
               winv_ff  <= !in_range;
               wacpt_ff <= 1'b0;
               if (in_range) begin
                  wph_ff  <= ph_ff[idx];
                  wpos_ff <= pos_ff[idx];
                  wsp_ff  <= spd_ff[idx];
                  if (kind_ff == REQ_STOP) begin
                     wacpt_ff    <= 1'b1;
                     wph_ff      <= PH_DONE;
                     wsp_ff      <= '0;
                     ph_ff[idx]  <= PH_DONE;
                     spd_ff[idx] <= '0;
                     if (home_ff) begin
                        wpos_ff     <= '0;
                        pos_ff[idx] <= '0;
                        tgt_ff[idx] <= '0;
                     end else begin
                        tgt_ff[idx] <= pos_ff[idx];
                     end
                  end else if (ph_ff[idx] == PH_DONE) begin
                     wacpt_ff    <= 1'b1;
                     wph_ff      <= PH_ACC;
                     ph_ff[idx]  <= PH_ACC;
                     vs_ff[idx]  <= cvs_ff;
                     vm_ff[idx]  <= cvm_ff;
                     acc_ff[idx] <= cacc_ff;
                     dec_ff[idx] <= cdec_ff;
                     tgt_ff[idx] <= (kind_ff == REQ_ABS) ? amt_ff : rel_tgt;
                  end
               end
            end
            S_LOAD: begin
               winv_ff  <= 1'b0;
               wacpt_ff <= 1'b1;
               wph_ff   <= ph_ff[idx];
               wpos_ff  <= pos_ff[idx];
               wtgt_ff  <= tgt_ff[idx];
               wsp_ff   <= spd_ff[idx];
               wvs_ff   <= vs_ff[idx];
               wvm_ff   <= vm_ff[idx];
               wacc_ff  <= acc_ff[idx];
               wdec_ff  <= dec_ff[idx];
               left_ff  <= diff[POS_W] ? LEFT_W'(-diff) : LEFT_W'(diff);
               rng_ff   <= ld_rng;
               dv_ff    <= ld_dv;
               brake_ff <= '0;
               if (ph_ff[idx] == PH_DONE)
                  state_ff <= S_EMIT;
               else if (ph_ff[idx] != PH_DEC && bval)
                  state_ff <= S_BMUL;
               else
                  state_ff <= S_DECIDE;
            end
            S_BMUL:    state_ff <= S_BDIV_GO;
            S_BDIV_GO: state_ff <= S_BDIV;
            S_BDIV: begin
               if (div_rsp.done) state_ff <= S_BMUL2;
            end
            S_BMUL2:   state_ff <= S_BRK;
            S_BRK: begin
               brake_ff <= prod_ff[POS_W+15:16];
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               state_ff <= S_PMUL;
               if (wph_ff == PH_DEC) begin
                  if (wsp_ff > wvs_ff) state_ff <= S_RMUL;
               end else if ({1'b0, brake_ff} >= left_ff) begin
                  wph_ff <= PH_DEC;
               end else if (wph_ff == PH_ACC && wsp_ff < wvm_ff) begin
                  state_ff <= S_RMUL;
               end
            end
            S_RMUL:    state_ff <= S_RDIV_GO;
            S_RDIV_GO: state_ff <= S_RDIV;
            S_RDIV: begin
               if (div_rsp.done) state_ff <= S_RAPPLY;
            end
            S_RAPPLY: begin
               state_ff <= S_PMUL;
               if (wph_ff == PH_ACC) begin
                  if (acc_sum >= {9'd0, wvm_ff}) begin
                     wsp_ff <= wvm_ff;
                     wph_ff <= PH_CRUISE;
                  end else begin
                     wsp_ff <= acc_sum[SPD_W-1:0];
                  end
               end else begin
                  wsp_ff <= ({9'd0, wsp_ff} > dec_lim) ? wsp_ff - dlt[SPD_W-1:0] : wvs_ff;
               end
            end
            S_PMUL: begin
               wsp_ff   <= spf;
               state_ff <= S_STEP;
            end
            S_STEP: begin
               state_ff <= S_EMIT;
               if ({9'd0, pitch} >= left_ff) begin
                  wpos_ff     <= wtgt_ff;
                  wsp_ff      <= '0;
                  wph_ff      <= PH_DONE;
                  pos_ff[idx] <= wtgt_ff;
                  spd_ff[idx] <= '0;
                  ph_ff[idx]  <= PH_DONE;
               end else begin
                  spd_ff[idx] <= wsp_ff;
                  ph_ff[idx]  <= wph_ff;
                  if (wtgt_ff > wpos_ff) begin
                     wpos_ff     <= wpos_ff + $signed({8'd0, pitch});
                     pos_ff[idx] <= wpos_ff + $signed({8'd0, pitch});
                  end else begin
                     wpos_ff     <= wpos_ff - $signed({8'd0, pitch});
                     pos_ff[idx] <= wpos_ff - $signed({8'd0, pitch});
                  end
               end
            end
            S_EMIT: begin
               if (rsp_tready) begin
                  if (tickm_ff && !last_axis) begin
                     cur_ff   <= cur_ff + 3'd1;
                     state_ff <= S_LOAD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = state_ff == S_EMIT;
   assign rsp_tlast  = !tickm_ff || last_axis;
   assign rsp_tdata  = {3'd0,
                        wacpt_ff,
                        !winv_ff && wph_ff != PH_DONE,
                        winv_ff ? {SPD_W{1'b0}} : wsp_ff,
                        winv_ff ? {POS_W{1'b0}} : wpos_ff,
                        cur_ff};

   // no word taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while result pending");

   // only a tick gives results that are not last, and those are always accepted
   a_tick_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[84])
      else $error("non-final result not accepted");

   // after the final result is taken the block is ready again
   a_ready_after: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not ready after final result");

endmodule
